// File: sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine package
// Constants, byte select codes and the command and status types that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int unsigned NUM_CHAIN = 5;
    localparam int unsigned NUM_BLOCK_WORDS = 16;

    localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD = 3'd4;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      put;
        t_byte_sel sel;
        logic      count;
        logic      round;
        logic      add;
        logic      reinit;
        logic [2:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
    } t_sts;

endpackage

// File: sv/sha1md_ifs.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine channels
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1md_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       is_last;

    modport source (output valid, data_byte, byte_valid, is_last, input ready);
    modport sink (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sha1md_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        word_last;

    modport source (output valid, digest_word, word_last, input ready);
    modport sink (input valid, digest_word, word_last, output ready);
endinterface

// File: sv/sha1md_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine datapath
// Block shift line with message schedule, round unit, chaining words,
// byte position and bit count.
// ----------------------------------------------------------------------------
module sha1md_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1md_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_data_byte,
    output sha1md_pkg::t_sts   o_sts,
    output logic [31:0]        o_digest_word
);
    import sha1md_pkg::*;

    logic [31:0] r_h [NUM_CHAIN];
    logic [31:0] r_v [NUM_CHAIN];
    logic [31:0] r_w [NUM_BLOCK_WORDS];
    logic [23:0] r_acc;
    logic [5:0]  r_pos;
    logic [63:0] r_cnt;
    logic [6:0]  r_rnd;

    logic [7:0]  n_byte;
    logic [7:0]  len_byte;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] n_a;
    logic [31:0] sched_x;
    logic [31:0] n_sched;

    // Length bytes go out most significant first, at positions 56 to 63.
    assign len_byte = r_cnt[{3'd7 - r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        case (i_cmd.sel)
            SEL_DATA: n_byte = i_data_byte;
            SEL_PAD:  n_byte = PAD_BYTE;
            SEL_ZERO: n_byte = 8'd0;
            SEL_LEN:  n_byte = len_byte;
            default:  n_byte = 8'd0;
        endcase
    end

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k_val = K_0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k_val = K_2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_3;
        end
        n_a = {r_v[0][26:0], r_v[0][31:27]} + f_val + r_v[4] + k_val + r_w[0];
        sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        n_sched = {sched_x[30:0], sched_x[31]};
    end

    always_comb begin
        case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = r_h[0];
        endcase
    end

    assign o_sts.pos = r_pos;
    assign o_sts.round_last = (r_rnd == LAST_ROUND);

    // Chaining words, byte position and bit count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= H_INIT;
            r_pos <= 6'd0;
            r_cnt <= 64'd0;
        end else if (i_cmd.reinit) begin
            r_h   <= H_INIT;
            r_pos <= 6'd0;
            r_cnt <= 64'd0;
        end else begin
            if (i_cmd.count) begin
                r_cnt <= r_cnt + 64'd8;
            end
            if (i_cmd.put) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.add) begin
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    // Block shift line, working variables and round counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_acc <= {r_acc[15:0], n_byte};
            if (r_pos[1:0] == 2'b11) begin
                for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[NUM_BLOCK_WORDS - 1] <= {r_acc, n_byte};
            end
            // The byte that fills the block also seeds the rounds.
            if (r_pos == LAST_POS) begin
                r_v   <= r_h;
                r_rnd <= 7'd0;
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[NUM_BLOCK_WORDS - 1] <= n_sched;
            r_v[0] <= n_a;
            r_v[1] <= r_v[0];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
            r_rnd  <= r_rnd + 7'd1;
        end
    end

endmodule

// File: sv/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine controller
// Sequences byte intake, rounds, padding and digest word output.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_byte_valid,
    input  logic             i_is_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic             o_word_last,
    input  logic             i_out_ready,
    input  sha1md_pkg::t_sts i_sts,
    output sha1md_pkg::t_cmd o_cmd
);
    import sha1md_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PH_ONE,
        PH_ZERO,
        PH_LEN
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic       r_pad, n_pad;
    logic [2:0] r_widx, n_widx;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_pad = r_pad;
        n_widx = r_widx;
        o_cmd = '0;
        o_cmd.sel = SEL_DATA;
        o_cmd.word_idx = r_widx;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_word_last = (r_widx == LAST_WORD);

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.put = i_byte_valid;
                    o_cmd.count = i_byte_valid;
                    if (i_byte_valid && i_sts.pos == LAST_POS) begin
                        n_state = ST_ROUND;
                        n_pad = i_is_last;
                        n_phase = PH_ONE;
                    end else if (i_is_last) begin
                        n_state = ST_PAD;
                        n_pad = 1'b1;
                        n_phase = PH_ONE;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                if (!r_pad) begin
                    n_state = ST_IDLE;
                end else if (r_phase == PH_LEN) begin
                    n_state = ST_OUT;
                    n_widx = 3'd0;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.put = 1'b1;
                case (r_phase)
                    PH_ONE: begin
                        o_cmd.sel = SEL_PAD;
                        n_phase = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (i_sts.pos == LEN_POS) begin
                            o_cmd.sel = SEL_LEN;
                            n_phase = PH_LEN;
                        end else begin
                            o_cmd.sel = SEL_ZERO;
                        end
                    end
                    PH_LEN: o_cmd.sel = SEL_LEN;
                    default: o_cmd.sel = SEL_ZERO;
                endcase
                if (i_sts.pos == LAST_POS) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_widx == LAST_WORD) begin
                        o_cmd.reinit = 1'b1;
                        n_state = ST_IDLE;
                        n_pad = 1'b0;
                        n_phase = PH_ONE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_ONE;
            r_pad   <= 1'b0;
            r_widx  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_widx  <= n_widx;
        end
    end

endmodule

// File: sv/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest engine
// Takes message bytes, pads the message and returns the five digest words.
// ----------------------------------------------------------------------------
//  Port      Dir  Carries                              Accepted when
//  i_byte    in   data_byte, byte_valid, is_last       valid && ready
//  o_word    out  digest_word, word_last               valid && ready
//
//  The byte that fills a 64-byte block starts 80 rounds of the single round
//  unit and then a fold of the result into the chaining words, during which
//  no byte is taken. A final word pads one byte per cycle, save during a
//  block's rounds (up to 72 bytes, one or two blocks), then holds the five
//  digest words until each is taken; no input meanwhile. Reset loads the
//  initial chaining words and clears the count.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1md_byte_if.sink  i_byte,
    sha1md_word_if.source o_word
);
    import sha1md_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha1md_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_byte.valid),
        .i_byte_valid (i_byte.byte_valid),
        .i_is_last    (i_byte.is_last),
        .o_in_ready   (i_byte.ready),
        .o_out_valid  (o_word.valid),
        .o_word_last  (o_word.word_last),
        .i_out_ready  (o_word.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    sha1md_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_byte.data_byte),
        .o_sts         (sts),
        .o_digest_word (o_word.digest_word)
    );

endmodule

// File: test/sha1md_digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 digest engine checker
// Watches the byte and digest channels, keeps its own SHA-1 state to work out
// the five digest words of every finished message, and compares each digest
// word the engine hands out with the oldest one still due.
// ----------------------------------------------------------------------------
module sha1md_digest_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sha1md_byte_if byte_ch,
    sha1md_word_if word_ch,
    output int     o_fail_count,
    output int     o_words_pending
);
    import sha1md_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_digest_entry;

    t_digest_entry digest_words_due[$];

    logic [31:0] chain_h [NUM_CHAIN];
    logic [31:0] block_w [NUM_BLOCK_WORDS];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    int mismatch_total = 0;
    int words_due_count = 0;

    assign o_fail_count = mismatch_total;
    assign o_words_pending = words_due_count;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic restart_message();
        int i;
        for (i = 0; i < NUM_CHAIN; i++) chain_h[i] = H_INIT[i];
        msg_bits = '0;
        fill_pos = '0;
    endtask

    task automatic fold_block();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int t;
        for (t = 0; t < 16; t++) sched[t] = block_w[t];
        for (t = 16; t < 80; t++) begin
            sched[t] = rotl(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            tmp = rotl(a, 5) + f + e + k + sched[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Bytes pack big-endian; the first byte of a word clears the rest of it.
    task automatic absorb_byte(input logic [7:0] v);
        logic [4:0]  sh;
        logic [31:0] lane;
        sh = {~fill_pos[1:0], 3'b000};
        lane = {24'd0, v} << sh;
        if (fill_pos[1:0] == 2'd0) begin
            block_w[fill_pos[5:2]] = lane;
        end else begin
            block_w[fill_pos[5:2]] |= lane;
        end
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) fold_block();
    endtask

    task automatic predict_digest(input logic [7:0] data, input logic has_byte,
                                  input logic ends_msg);
        logic [63:0]   msg_len;
        t_digest_entry entry;
        int i;
        if (has_byte) begin
            msg_bits += 64'd8;
            absorb_byte(data);
        end
        if (ends_msg) begin
            msg_len = msg_bits;
            absorb_byte(PAD_BYTE);
            while (fill_pos != LEN_POS) absorb_byte(8'h00);
            for (i = 0; i < 8; i++) absorb_byte(msg_len[8*(7-i) +: 8]);
            for (i = 0; i < NUM_CHAIN; i++) begin
                entry.digest_word = chain_h[i];
                entry.word_last = (i == int'(LAST_WORD));
                digest_words_due.insert(digest_words_due.size(), entry);
            end
            restart_message();
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_entry due;
        if (!i_rst_n) begin
            restart_message();
            digest_words_due.delete();
        end else begin
            if (word_ch.valid && word_ch.ready) begin
                if (digest_words_due.size() == 0) begin
                    $error("digest_word: none expected, actual %h", word_ch.digest_word);
                    mismatch_total++;
                end else begin
                    due = digest_words_due.pop_front();
                    if (word_ch.digest_word !== due.digest_word) begin
                        $error("digest_word: expected %h, actual %h",
                               due.digest_word, word_ch.digest_word);
                        mismatch_total++;
                    end
                    if (word_ch.word_last !== due.word_last) begin
                        $error("word_last: expected %b, actual %b",
                               due.word_last, word_ch.word_last);
                        mismatch_total++;
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                predict_digest(byte_ch.data_byte, byte_ch.byte_valid, byte_ch.is_last);
            end
        end
        words_due_count <= digest_words_due.size();
    end

endmodule

// File: test/tb_sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest engine testbench
// Feeds directed and random messages byte by byte, with random gaps and
// back-pressure, and lets the checker compare every digest word.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 420;
    localparam int TAIL_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    int random_items = 0;
    bit sender_steady = 1'b0;

    sha1md_byte_if byte_ch ();
    sha1md_word_if word_ch ();

    sha1_message_digest i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_word  (word_ch.source)
    );

    sha1md_digest_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .byte_ch         (byte_ch),
        .word_ch         (word_ch),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.byte_valid = 1'b0;
        byte_ch.is_last = 1'b0;
        word_ch.ready = 1'b0;
    end

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_sha1_message_digest NOT OK");
        $finish;
    end

    // Ready is sampled right after the edge, so it is the value the edge saw.
    task automatic send_byte_word(input logic [7:0] data, input logic has_byte,
                                  input logic ends_msg);
        while (!sender_steady && $urandom_range(99) < 23) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.byte_valid <= has_byte;
        byte_ch.is_last <= ends_msg;
        do @(posedge i_clk); while (!byte_ch.ready);
        random_items++;
    endtask

    task automatic wait_words_drained();
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    // Random content; now and then a word without a byte is slipped in.
    task automatic send_message(input int len);
        bit last_on_byte;
        int i;
        last_on_byte = (len > 0) && $urandom_range(1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 5) begin
                send_byte_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_byte_word(8'($urandom_range(255)), 1'b1, last_on_byte && (i == len - 1));
        end
        if (!last_on_byte) begin
            send_byte_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int boundary_len [8];
        int msg_count;
        int len;
        int pick;
        boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
        msg_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message.
        send_byte_word(8'h5A, 1'b0, 1'b1);
        // "abc", ended on its last byte.
        send_byte_word(8'h61, 1'b1, 1'b0);
        send_byte_word(8'h62, 1'b1, 1'b0);
        send_byte_word(8'h63, 1'b1, 1'b1);
        // Extreme bytes, an ignored word between them, then an end without a byte.
        send_byte_word(8'h00, 1'b1, 1'b0);
        send_byte_word(8'hA5, 1'b0, 1'b0);
        send_byte_word(8'hFF, 1'b1, 1'b0);
        send_byte_word(8'hFF, 1'b0, 1'b1);
        // One-byte messages.
        send_byte_word(8'hFF, 1'b1, 1'b1);
        send_byte_word(8'h00, 1'b1, 1'b1);
        send_byte_word(8'h80, 1'b1, 1'b1);
        byte_ch.valid <= 1'b0;
        wait_words_drained();

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(40);
            end else if (pick < 85) begin
                len = boundary_len[$urandom_range(7)];
            end else begin
                len = $urandom_range(130, 41);
            end
            sender_steady = (msg_count >= 3) && (msg_count < 7);
            send_message(len);
            msg_count++;
            if (msg_count == 9) begin
                byte_ch.valid <= 1'b0;
                wait_words_drained();
            end
        end
        byte_ch.valid <= 1'b0;

        wait_words_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("tb_sha1_message_digest OK");
        end else begin
            $display("tb_sha1_message_digest NOT OK");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off, a clean stretch, then random.
    initial begin
        int n;
        for (n = 0; n < 600; n++) begin
            @(posedge i_clk);
            word_ch.ready <= ($urandom_range(99) >= 23);
        end
        for (n = 0; n < 500; n++) begin
            @(posedge i_clk);
            word_ch.ready <= 1'b0;
        end
        for (n = 0; n < 2000; n++) begin
            @(posedge i_clk);
            word_ch.ready <= 1'b1;
        end
        forever begin
            @(posedge i_clk);
            word_ch.ready <= ($urandom_range(99) >= 23);
        end
    end

endmodule
